>>> src/lav_pkg.sv
// Shared types, constants and helper functions for the look-at view matrix block.
// Used by lav_norm, look_at_view_matrix_top and the testbench; depends on nothing.
package lav_pkg;

  localparam int COORD_W   = 32;                 // width of one input coordinate
  localparam int IN_W      = 9 * COORD_W;        // packed input beat
  localparam int NORM_BITS = 30;                 // the largest scaled magnitude lies in [2^29, 2^30)
  localparam int SQ_STEPS  = NORM_BITS + 1;      // one root bit per stage
  localparam int SUMW      = 2 * NORM_BITS + 2;  // sum of three squares

  // Pipeline control handed to a sub-pipeline: advance enable and entering valid bit.
  typedef struct packed {
    logic en;
    logic valid;
  } lav_ctl_t;

  // Number of significant bits in one byte.
  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Divide by 2^s, rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] m;
    logic [63:0] r;
    m = v[63] ? 64'(-v) : 64'(v);
    r = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

endpackage

>>> src/look_at_view_matrix_top.sv
// Top level of the look-at view matrix pipeline: stream ports and arithmetic stages.
// Depends on lav_pkg and lav_norm.
//
//  Channel   Direction  Beat contents
//  s_axis    in         eye x,y,z, aim x,y,z, hint x,y,z (9 x 32-bit Q16.16)
//  m_axis    out        right, upaxis, look (9 x Q1.FRAC) then shift x,y,z (3 x 32-bit)
//
// One beat enters per clock unless a held output beat stalls the pipeline. Most of the
// pipeline depth lies in the two normalizers, each a bit-per-stage square root
// (31 stages) followed by a bit-per-stage divider (FRAC_BITS + 2 stages).
// Reset is synchronous and clears only the valid bits. When the output beat is held by
// m_axis_tready low, the whole pipeline holds and s_axis_tready drops in the same cycle.
module look_at_view_matrix_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, hint_x, hint_y, hint_z (lowest first)
  input  logic [lav_pkg::IN_W-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // right_x/y/z, upaxis_x/y/z, look_x/y/z, shift_x/y/z (lowest first), zero padded
  output logic [((9*(FRAC_BITS+2)+96+7)/8)*8-1:0] m_axis_tdata
);
  import lav_pkg::*;

  localparam int QW   = FRAC_BITS + 2;        // unit entry width
  localparam int PW1  = COORD_W + QW;         // coordinate times unit entry
  localparam int SW1  = PW1 + 2;              // sum of three such products
  localparam int DOTW = 34;                   // rounded hint.look
  localparam int RMW  = FRAC_BITS + 35;       // up-axis remainder
  localparam int CPW  = 2 * QW;               // unit times unit
  localparam int CDW  = CPW + 1;
  localparam int ODW  = ((9*QW + 96 + 7) / 8) * 8;
  localparam int SB1W = 6 * COORD_W;
  localparam int SB2W = 3 * COORD_W + 3 * QW;
  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] SMAX  = 64'sd2147483647;
  localparam logic signed [63:0] SMIN  = -64'sd2147483648;

  // The whole pipeline advances unless a finished beat is waiting at the output.
  logic en;
  logic v10;
  assign en            = !v10 || m_axis_tready;
  assign s_axis_tready = en;

  // Input register.
  logic signed [COORD_W-1:0] eye0 [3], aim0 [3], hint0 [3];
  logic v0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye0[i]  <= s_axis_tdata[i*COORD_W +: COORD_W];
        aim0[i]  <= s_axis_tdata[(3+i)*COORD_W +: COORD_W];
        hint0[i] <= s_axis_tdata[(6+i)*COORD_W +: COORD_W];
      end
    end
  end

  // View direction before normalization.
  logic signed [COORD_W:0]   dir1 [3];
  logic signed [COORD_W-1:0] eye1 [3], hint1 [3];
  logic v1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dir1[i] <= (COORD_W+1)'(aim0[i]) - (COORD_W+1)'(eye0[i]);
      end
      eye1  <= eye0;
      hint1 <= hint0;
    end
  end

  // First normalizer: look = normalize(aim - eye). Eye and hint ride along.
  lav_ctl_t            ctl1;
  logic [SB1W-1:0]     sb1_in, sb1_out;
  logic                va;
  logic signed [QW-1:0] look_a [3];
  logic signed [COORD_W-1:0] eye_a [3], hint_a [3];

  assign ctl1   = '{en: en, valid: v1};
  assign sb1_in = {hint1[2], hint1[1], hint1[0], eye1[2], eye1[1], eye1[0]};

  lav_norm #(.IW(COORD_W + 1), .FRAC(FRAC_BITS), .SBW(SB1W)) u_norm_look (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl1),
    .vec       (dir1),
    .sb_in     (sb1_in),
    .valid_out (va),
    .unit      (look_a),
    .sb_out    (sb1_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_a[i]  = sb1_out[i*COORD_W +: COORD_W];
      hint_a[i] = sb1_out[(3+i)*COORD_W +: COORD_W];
    end
  end

  // hint . look: products, sum, rounding.
  logic signed [PW1-1:0]     hp2 [3];
  logic signed [SW1-1:0]     s3;
  logic signed [DOTW-1:0]    dot4;
  logic signed [COORD_W-1:0] eye2 [3], hint2 [3], eye3 [3], hint3 [3], eye4 [3], hint4 [3];
  logic signed [QW-1:0]      look2 [3], look3 [3], look4 [3];
  logic v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= va;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hp2[i] <= PW1'(hint_a[i]) * PW1'(look_a[i]);
      end
      eye2  <= eye_a;
      hint2 <= hint_a;
      look2 <= look_a;
      s3    <= SW1'(hp2[0]) + SW1'(hp2[1]) + SW1'(hp2[2]);
      eye3  <= eye2;
      hint3 <= hint2;
      look3 <= look2;
      dot4  <= DOTW'(rnd_shift(64'(s3), FRAC_BITS));
      eye4  <= eye3;
      hint4 <= hint3;
      look4 <= look3;
    end
  end

  // Remainder of the hint after the look component is removed.
  logic signed [RMW-1:0]     rem5 [3];
  logic signed [COORD_W-1:0] eye5 [3];
  logic signed [QW-1:0]      look5 [3];
  logic v5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        rem5[i] <= (RMW'(hint4[i]) <<< FRAC_BITS) - RMW'(look4[i]) * RMW'(dot4);
      end
      eye5  <= eye4;
      look5 <= look4;
    end
  end

  // Second normalizer: upaxis. Eye and look ride along.
  lav_ctl_t             ctl2;
  logic [SB2W-1:0]      sb2_in, sb2_out;
  logic                 vb;
  logic signed [QW-1:0] up_b [3], look_b [3];
  logic signed [COORD_W-1:0] eye_b [3];

  assign ctl2   = '{en: en, valid: v5};
  assign sb2_in = {look5[2], look5[1], look5[0], eye5[2], eye5[1], eye5[0]};

  lav_norm #(.IW(RMW), .FRAC(FRAC_BITS), .SBW(SB2W)) u_norm_up (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl2),
    .vec       (rem5),
    .sb_in     (sb2_in),
    .valid_out (vb),
    .unit      (up_b),
    .sb_out    (sb2_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_b[i]  = sb2_out[i*COORD_W +: COORD_W];
      look_b[i] = sb2_out[3*COORD_W + i*QW +: QW];
    end
  end

  // right = cross(upaxis, look): products, then difference, rounding and clamp.
  logic signed [CPW-1:0]     cp6 [6];
  logic signed [COORD_W-1:0] eye6 [3], eye7 [3];
  logic signed [QW-1:0]      up6 [3], look6 [3], up7 [3], look7 [3], right7 [3];
  logic signed [CDW-1:0]     cd [3];
  logic signed [63:0]        cr [3];
  logic signed [QW-1:0]      right_c [3];
  logic v6, v7;

  always_comb begin
    cd[0] = CDW'(cp6[0]) - CDW'(cp6[1]);
    cd[1] = CDW'(cp6[2]) - CDW'(cp6[3]);
    cd[2] = CDW'(cp6[4]) - CDW'(cp6[5]);
    for (int i = 0; i < 3; i++) begin
      cr[i] = rnd_shift(64'(cd[i]), FRAC_BITS);
      if (cr[i] > ONE64) right_c[i] = QW'(ONE64);
      else if (cr[i] < -ONE64) right_c[i] = QW'(-ONE64);
      else right_c[i] = QW'(cr[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v6 <= vb;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp6[0] <= CPW'(up_b[1]) * CPW'(look_b[2]);
      cp6[1] <= CPW'(up_b[2]) * CPW'(look_b[1]);
      cp6[2] <= CPW'(up_b[2]) * CPW'(look_b[0]);
      cp6[3] <= CPW'(up_b[0]) * CPW'(look_b[2]);
      cp6[4] <= CPW'(up_b[0]) * CPW'(look_b[1]);
      cp6[5] <= CPW'(up_b[1]) * CPW'(look_b[0]);
      eye6   <= eye_b;
      up6    <= up_b;
      look6  <= look_b;
      right7 <= right_c;
      eye7   <= eye6;
      up7    <= up6;
      look7  <= look6;
    end
  end

  // Translation row: eye dotted with each axis, negated and saturated.
  // Axis index 0 is right, 1 is upaxis, 2 is look.
  logic signed [QW-1:0]  ax7 [3][3];
  logic signed [QW-1:0]  ax8 [3][3], ax9 [3][3], ax10 [3][3];
  logic signed [PW1-1:0] ep8 [3][3];
  logic signed [SW1-1:0] es9 [3];
  logic signed [63:0]    tr [3];
  logic signed [COORD_W-1:0] sh_c [3], sh10 [3];
  logic v8, v9;

  assign ax7[0] = right7;
  assign ax7[1] = up7;
  assign ax7[2] = look7;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      tr[a] = -rnd_shift(64'(es9[a]), FRAC_BITS);
      if (tr[a] > SMAX) sh_c[a] = COORD_W'(SMAX);
      else if (tr[a] < SMIN) sh_c[a] = COORD_W'(SMIN);
      else sh_c[a] = COORD_W'(tr[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else if (en) begin
      v8  <= v7;
      v9  <= v8;
      v10 <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) begin
          ep8[a][i] <= PW1'(eye7[i]) * PW1'(ax7[a][i]);
        end
        es9[a] <= SW1'(ep8[a][0]) + SW1'(ep8[a][1]) + SW1'(ep8[a][2]);
      end
      ax8  <= ax7;
      ax9  <= ax8;
      ax10 <= ax9;
      sh10 <= sh_c;
    end
  end

  assign m_axis_tvalid = v10;
  assign m_axis_tdata  = ODW'({sh10[2], sh10[1], sh10[0],
                               ax10[2][2], ax10[2][1], ax10[2][0],
                               ax10[1][2], ax10[1][1], ax10[1][0],
                               ax10[0][2], ax10[0][1], ax10[0][0]});

endmodule

>>> src/lav_norm.sv
// Pipelined three-component vector normalizer: scaling, squares, root and divide.
// Depends on lav_pkg; instantiated twice by look_at_view_matrix_top.
module lav_norm #(
  parameter int IW   = 33,
  parameter int FRAC = 16,
  parameter int SBW  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lav_pkg::lav_ctl_t     ctl,
  input  logic signed [IW-1:0]  vec [3],
  input  logic [SBW-1:0]        sb_in,
  output logic                  valid_out,
  output logic signed [FRAC+1:0] unit [3],
  output logic [SBW-1:0]        sb_out
);
  import lav_pkg::*;

  localparam int NG  = (IW + 7) / 8;
  localparam int BLW = $clog2(IW + 1);
  localparam int QW  = FRAC + 2;
  localparam int RW  = FRAC + 32;
  localparam int DW  = FRAC + 33;
  localparam int LW  = NORM_BITS + 1;
  localparam int DVW = NORM_BITS + 2;
  localparam int CXW = SBW + 4;

  logic en;
  assign en = ctl.en;

  // Magnitudes and signs.
  logic [IW-1:0]  m0 [3];
  logic [2:0]     ng0;
  logic [SBW-1:0] sb0;
  logic           v0;

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= ctl.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m0[i]  <= vec[i][IW-1] ? (~vec[i] + 1'b1) : vec[i];
        ng0[i] <= vec[i][IW-1];
      end
      sb0 <= sb_in;
    end
  end

  // Per-byte leading one search.
  logic [NG*8-1:0] orp;
  logic [NG-1:0]   nz1;
  logic [3:0]      lb1 [NG];
  logic [IW-1:0]   m1 [3];
  logic [2:0]      ng1;
  logic [SBW-1:0]  sb1;
  logic            v1;

  assign orp = (NG*8)'(m0[0] | m0[1] | m0[2]);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NG; g++) begin
        nz1[g] <= |orp[g*8 +: 8];
        lb1[g] <= bitlen8(orp[g*8 +: 8]);
      end
      m1  <= m0;
      ng1 <= ng0;
      sb1 <= sb0;
    end
  end

  // Bit length of the largest magnitude.
  logic [BLW-1:0] bl_c;
  logic [BLW-1:0] bl2;
  logic [IW-1:0]  m2 [3];
  logic [CXW-1:0] cx2;
  logic           v2;

  always_comb begin
    bl_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (nz1[g]) bl_c = BLW'(g * 8) + BLW'(lb1[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bl2 <= bl_c;
      m2  <= m1;
      cx2 <= {sb1, (bl_c == '0), ng1};
    end
  end

  // Scale so that the largest magnitude has exactly NORM_BITS bits.
  logic [IW-1:0]        tsh [3];
  logic [NORM_BITS-1:0] m30c [3];
  logic [NORM_BITS-1:0] m3 [3];
  logic [CXW-1:0]       cx3;
  logic                 v3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tsh[i] = m2[i] >> (bl2 - BLW'(NORM_BITS));
      if (bl2 > BLW'(NORM_BITS)) m30c[i] = tsh[i][NORM_BITS-1:0];
      else m30c[i] = m2[i][NORM_BITS-1:0] << (BLW'(NORM_BITS) - bl2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m3  <= m30c;
      cx3 <= cx2;
    end
  end

  // Squares, then their sum.
  logic [2*NORM_BITS-1:0] sq4 [3];
  logic [NORM_BITS-1:0]   m4 [3];
  logic [CXW-1:0]         cx4;
  logic                   v4;
  logic [SUMW-1:0]        sum5;
  logic [NORM_BITS-1:0]   m5 [3];
  logic [CXW-1:0]         cx5;
  logic                   v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= (2*NORM_BITS)'(m3[i]) * (2*NORM_BITS)'(m3[i]);
      end
      m4   <= m3;
      cx4  <= cx3;
      sum5 <= SUMW'(sq4[0]) + SUMW'(sq4[1]) + SUMW'(sq4[2]);
      m5   <= m4;
      cx5  <= cx4;
    end
  end

  // Integer square root, one result bit per stage.
  logic [SUMW-1:0]      srem  [SQ_STEPS];
  logic [SUMW-1:0]      sroot [SQ_STEPS];
  logic                 sv    [SQ_STEPS];
  logic [CXW-1:0]       scx   [SQ_STEPS];
  logic [NORM_BITS-1:0] sm    [SQ_STEPS][3];

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sqrt
    localparam int K = NORM_BITS - s;
    logic [SUMW-1:0]      rin, qin, rnx, qnx;
    logic [SUMW:0]        onev, trial;
    logic                 vin;
    logic [CXW-1:0]       cin;
    logic [NORM_BITS-1:0] mi [3];

    if (s == 0) begin : g_first
      assign rin = sum5;
      assign qin = '0;
      assign vin = v5;
      assign cin = cx5;
      assign mi  = m5;
    end else begin : g_next
      assign rin = srem[s-1];
      assign qin = sroot[s-1];
      assign vin = sv[s-1];
      assign cin = scx[s-1];
      assign mi  = sm[s-1];
    end

    always_comb begin
      onev  = (SUMW+1)'(1) << (2 * K);
      trial = {1'b0, qin} + onev;
      if ({1'b0, rin} >= trial) begin
        rnx = rin - trial[SUMW-1:0];
        qnx = (qin >> 1) + onev[SUMW-1:0];
      end else begin
        rnx = rin;
        qnx = qin >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sv[s] <= 1'b0;
      else if (en) sv[s] <= vin;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem[s]  <= rnx;
        sroot[s] <= qnx;
        scx[s]   <= cin;
        sm[s]    <= mi;
      end
    end
  end

  // Divider setup: numerator m * 2^(FRAC+1) + len, divisor 2 * len.
  logic [LW-1:0]  len;
  logic [RW-1:0]  r6 [3];
  logic [DVW-1:0] d6;
  logic [CXW-1:0] cx6;
  logic           v6;

  assign len = sroot[SQ_STEPS-1][LW-1:0];

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= sv[SQ_STEPS-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r6[i] <= (RW'(sm[SQ_STEPS-1][i]) << (FRAC + 1)) + RW'(len);
      end
      d6  <= {len, 1'b0};
      cx6 <= scx[SQ_STEPS-1];
    end
  end

  // Restoring division, one quotient bit per stage for all three components.
  logic [RW-1:0]  dr  [QW][3];
  logic [QW-1:0]  dq  [QW][3];
  logic [DVW-1:0] dd  [QW];
  logic           dv  [QW];
  logic [CXW-1:0] dcx [QW];

  for (genvar t = 0; t < QW; t++) begin : g_div
    localparam int B = QW - 1 - t;
    logic [RW-1:0]  ri [3];
    logic [QW-1:0]  qi [3];
    logic [RW-1:0]  rn [3];
    logic [QW-1:0]  qn [3];
    logic [DVW-1:0] di;
    logic [DW-1:0]  shd;
    logic           vin;
    logic [CXW-1:0] cin;

    if (t == 0) begin : g_first
      assign ri  = r6;
      assign qi  = '{default: '0};
      assign di  = d6;
      assign vin = v6;
      assign cin = cx6;
    end else begin : g_next
      assign ri  = dr[t-1];
      assign qi  = dq[t-1];
      assign di  = dd[t-1];
      assign vin = dv[t-1];
      assign cin = dcx[t-1];
    end

    always_comb begin
      shd = DW'(di) << B;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, ri[i]} >= shd) begin
          rn[i] = ri[i] - shd[RW-1:0];
          qn[i] = qi[i] | (QW'(1) << B);
        end else begin
          rn[i] = ri[i];
          qn[i] = qi[i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv[t] <= 1'b0;
      else if (en) dv[t] <= vin;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[t]  <= rn;
        dq[t]  <= qn;
        dd[t]  <= di;
        dcx[t] <= cin;
      end
    end
  end

  // Clamp to one, restore signs; a zero vector gives zero.
  logic [CXW-1:0]       cxl;
  logic [QW-1:0]        qc [3];
  logic signed [QW-1:0] uo [3];
  logic [SBW-1:0]       sbo;
  logic                 vo;

  assign cxl = dcx[QW-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (dq[QW-1][i] > (QW'(1) << FRAC)) ? (QW'(1) << FRAC) : dq[QW-1][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vo <= 1'b0;
    else if (en) vo <= dv[QW-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (cxl[3]) uo[i] <= '0;
        else if (cxl[i]) uo[i] <= -$signed(qc[i]);
        else uo[i] <= $signed(qc[i]);
      end
      sbo <= cxl[CXW-1:4];
    end
  end

  assign valid_out = vo;
  assign unit      = uo;
  assign sb_out    = sbo;

endmodule

>>> src/lav_checker.sv
// Port-level checker for look_at_view_matrix_top, attached by the bind at the end.
// Depends only on the port widths of the top level, given by FRAC_BITS.
module lav_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    s_axis_tready,
  input logic                    m_axis_tvalid,
  input logic                    m_axis_tready,
  input logic [((9*(FRAC_BITS+2)+96+7)/8)*8-1:0] m_axis_tdata
);
  localparam int QW = FRAC_BITS + 2;
  localparam logic signed [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic signed [QW-1:0] look_x, upaxis_x;
  assign upaxis_x = m_axis_tdata[3*QW +: QW];
  assign look_x   = m_axis_tdata[6*QW +: QW];

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat valid right after reset");

  // The input side is open exactly when the output is empty or being taken.
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
      s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // A held output beat stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("held output beat changed");

  // The x entries of look and upaxis never exceed one in magnitude.
  a_unit_range: assert property (@(posedge clk) disable iff (rst)
      m_axis_tvalid |-> (look_x <= ONE_Q) && (look_x >= -ONE_Q)
                     && (upaxis_x <= ONE_Q) && (upaxis_x >= -ONE_Q))
    else $error("rotation entry out of range");

endmodule

bind look_at_view_matrix_top lav_checker #(.FRAC_BITS(FRAC_BITS)) u_lav_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/look_at_view_matrix_top_tb.sv
// Self-checking testbench for look_at_view_matrix_top: directed and random camera setups
// go in as random bursts, and each output beat is checked field by field against a built-in predictor.
// Depends on lav_pkg and look_at_view_matrix_top.
`timescale 1ns / 100ps

module look_at_view_matrix_top_tb;

  localparam int FRAC      = 16;
  localparam int ROT_W     = FRAC + 2;
  localparam int OUT_W     = ((9 * ROT_W + 96 + 7) / 8) * 8;
  localparam int LATENCY   = 2 * FRAC + 93;
  localparam int IDLE_MAX  = 4000;   // cycles with no beat on either side
  localparam int N_RANDOM  = 1680;

  typedef longint vec3_t [3];

  // One pending input beat; a drain beat waits until every matrix has come back.
  typedef struct {
    logic [lav_pkg::IN_W-1:0] data;
    bit                       drain;
  } setup_t;

  logic                     clk;
  logic                     rst;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [lav_pkg::IN_W-1:0] s_axis_tdata;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_W-1:0]         m_axis_tdata;

  setup_t           setup_q[$];     // beats still to be sent
  logic [OUT_W-1:0] matrix_q[$];    // predicted output beats, oldest first
  int               mismatches;
  int               idle_cycles;
  int               burst_left;
  int               gap_left;
  int               rx_run;
  int               rx_stall;

  look_at_view_matrix_top #(.FRAC_BITS(FRAC)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is done in 64-bit integers, which hold every
  // intermediate product exactly for Q16.16 inputs.
  // ---------------------------------------------------------------------------
  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Divide by 2^FRAC, rounding half away from zero.
  function automatic longint round_frac(longint v);
    longint unsigned m;
    m = (abs64(v) + (64'd1 << (FRAC - 1))) >> FRAC;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned rest;
    longint unsigned root;
    longint unsigned bitv;
    rest = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rest >= root + bitv) begin
        rest = rest - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Unit vector in Q1.FRAC. The largest magnitude is first brought into
  // [2^29, 2^30), truncating on a right shift; a zero vector stays zero.
  function automatic void unit_vec(input vec3_t v, output vec3_t u);
    longint unsigned m[3];
    longint unsigned big;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    int nbits;
    big = 0;
    sum = 0;
    nbits = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = abs64(v[i]);
      if (m[i] > big) big = m[i];
    end
    if (big == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while ((big >> nbits) != 0) nbits++;
    for (int i = 0; i < 3; i++) begin
      if (nbits > 30) m[i] = m[i] >> (nbits - 30);
      else m[i] = m[i] << (30 - nbits);
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (FRAC + 1)) + len) / (len * 2);
      if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = longint'(1) << FRAC;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // Negated dot product, rounded and saturated to signed 32 bits.
  function automatic logic [31:0] neg_dot(vec3_t e, vec3_t a);
    longint r;
    r = -round_frac(e[0] * a[0] + e[1] * a[1] + e[2] * a[2]);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic logic [OUT_W-1:0] view_matrix(logic [lav_pkg::IN_W-1:0] d);
    vec3_t eye, aim, hint, dir, look, rest, up, right;
    longint dot;
    logic [OUT_W-1:0] beat;
    for (int i = 0; i < 3; i++) begin
      eye[i]  = longint'($signed(d[32*i +: 32]));
      aim[i]  = longint'($signed(d[32*(3+i) +: 32]));
      hint[i] = longint'($signed(d[32*(6+i) +: 32]));
      dir[i]  = aim[i] - eye[i];
    end
    unit_vec(dir, look);
    dot = round_frac(hint[0] * look[0] + hint[1] * look[1] + hint[2] * look[2]);
    for (int i = 0; i < 3; i++) rest[i] = hint[i] * (longint'(1) << FRAC) - look[i] * dot;
    unit_vec(rest, up);
    right[0] = clamp_unit(round_frac(up[1] * look[2] - up[2] * look[1]));
    right[1] = clamp_unit(round_frac(up[2] * look[0] - up[0] * look[2]));
    right[2] = clamp_unit(round_frac(up[0] * look[1] - up[1] * look[0]));
    beat = '0;
    for (int i = 0; i < 3; i++) begin
      beat[ROT_W*i +: ROT_W]     = right[i][ROT_W-1:0];
      beat[ROT_W*(3+i) +: ROT_W] = up[i][ROT_W-1:0];
      beat[ROT_W*(6+i) +: ROT_W] = look[i][ROT_W-1:0];
    end
    beat[9*ROT_W +: 32]      = neg_dot(eye, right);
    beat[9*ROT_W + 32 +: 32] = neg_dot(eye, up);
    beat[9*ROT_W + 64 +: 32] = neg_dot(eye, look);
    return beat;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic add_setup(input int c[9], input bit drain);
    setup_t s;
    for (int i = 0; i < 9; i++) s.data[32*i +: 32] = c[i];
    s.drain = drain;
    setup_q.push_back(s);
  endtask

  function automatic int pick_coord(int kind);
    case (kind)
      0: return $urandom;
      1: return $urandom_range(0, 8) == 0 ? ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000)
                                          : $urandom;
      default: return int'($urandom_range(0, 20'hfffff)) - 20'h80000;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats separated by random gaps. A new beat is chosen only
  // when the line is free, so tvalid never drops before its beat is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        matrix_q.push_back(view_matrix(s_axis_tdata));
        void'(setup_q.pop_front());
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (burst_left == 0) begin
          burst_left    <= $urandom_range(1, 40);
          gap_left      <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
          s_axis_tvalid <= 1'b0;
        end else if (setup_q.size() > 0 &&
                     (!setup_q[0].drain || matrix_q.size() == 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= setup_q[0].data;
          burst_left    <= burst_left - 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: the receiver alternates ready runs and stalls of random length,
  // and every taken beat is compared with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [OUT_W-1:0] want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_run        <= 0;
      rx_stall      <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("unexpected beat", m_axis_tdata[63:0], 64'd0);
        end else begin
          want = matrix_q.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (m_axis_tdata[ROT_W*i +: ROT_W] !== want[ROT_W*i +: ROT_W]) begin
              report_mismatch($sformatf("rotation entry %0d", i),
                              64'(m_axis_tdata[ROT_W*i +: ROT_W]),
                              64'(want[ROT_W*i +: ROT_W]));
            end
          end
          for (int i = 0; i < 3; i++) begin
            if (m_axis_tdata[9*ROT_W + 32*i +: 32] !== want[9*ROT_W + 32*i +: 32]) begin
              report_mismatch($sformatf("shift %0d", i),
                              64'(m_axis_tdata[9*ROT_W + 32*i +: 32]),
                              64'(want[9*ROT_W + 32*i +: 32]));
            end
          end
        end
      end
      if (rx_stall > 0) begin
        rx_stall      <= rx_stall - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_run > 0) begin
        rx_run        <= rx_run - 1;
        m_axis_tready <= 1'b1;
      end else begin
        rx_run        <= $urandom_range(1, 60);
        rx_stall      <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 30);
        m_axis_tready <= 1'b0;
      end
    end
  end

  // Watchdog: stop when neither side has moved a beat for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int c[9];
    int kind;
    int d[3];
    int k;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    mismatches    = 0;
    idle_cycles   = 0;
    rst           = 1'b1;

    // Directed setups: all zero, eye equal to aim, zero hint, hint along the
    // view direction, full-scale coordinates and translation overflow.
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                                   add_setup(c, 0);
    c = '{65536, 0, 0, 65536, 0, 0, 0, 65536, 0};                       add_setup(c, 0);
    c = '{0, 0, 0, 0, 0, 65536, 0, 0, 0};                               add_setup(c, 0);
    c = '{0, 0, 0, 0, 0, 65536, 0, 0, 131072};                          add_setup(c, 0);
    c = '{0, 0, 0, 0, 0, 65536, 0, 0, -65536};                          add_setup(c, 0);
    c = '{0, 0, -327680, 0, 0, 0, 0, 65536, 0};                         add_setup(c, 0);
    c = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
          32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};      add_setup(c, 0);
    c = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};      add_setup(c, 0);
    c = '{32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 65536, 0}; add_setup(c, 0);
    c = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 65536, 0, 0}; add_setup(c, 1);
    c = '{1, 0, 0, 0, 0, 0, 0, 1, 0};                                   add_setup(c, 0);
    c = '{-1, -1, -1, 1, 1, 1, -1, 1, -1};                              add_setup(c, 0);
    c = '{100, 200, 300, 100, 200, 300, 5, 6, 7};                       add_setup(c, 0);
    c = '{0, 0, 0, 3, 4, 0, 0, 0, 0};                                   add_setup(c, 0);
    c = '{0, 0, 0, 65536, 65536, 65536, 65536, 65536, 65536};           add_setup(c, 0);
    c = '{0, 0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0};             add_setup(c, 0);
    c = '{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h55555555, 32'haaaaaaaa,
          32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa};      add_setup(c, 0);

    // Random setups: general values, near full scale, small scenes, and the
    // degenerate ones with a parallel hint or eye on the target.
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) c[i] = pick_coord(kind < 3 ? 0 : (kind < 5 ? 1 : 2));
      if (kind == 7) begin
        for (int i = 0; i < 3; i++) c[3+i] = c[i];
      end else if (kind >= 8) begin
        k = int'($urandom_range(0, 6)) - 3;
        for (int i = 0; i < 3; i++) begin
          d[i]   = int'($urandom_range(0, 16'hffff)) - 16'h8000;
          c[3+i] = c[i] + d[i];
          c[6+i] = d[i] * k;
        end
      end
      add_setup(c, (n % 500) == 250);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (setup_q.size() == 0);
    wait (matrix_q.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);

    if (mismatches == 0 && matrix_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
